@@ design/mexp_pkg.sv @@
// Shared types for the modular exponentiation block.
package mexp_pkg;

	// Status of the shared modular multiplier as seen by its sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage

@@ design/mexp_modmul.sv @@
// Multi-cycle modular multiplier: one product, then restoring reduction two bits a cycle.
module mexp_modmul
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] op_a,
	input  logic [MOD_BITS-1:0] op_b,
	input  logic [MOD_BITS-1:0] modulus,
	output mm_status_t          status,
	output logic [MOD_BITS-1:0] result
);

	localparam int PROD_BITS = 2 * MOD_BITS;
	localparam int CNT_W     = $clog2(MOD_BITS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MOD_BITS - 1);

	typedef enum logic {
		MM_IDLE,
		MM_REDUCE
	} mm_state_t;

	mm_state_t            state_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [MOD_BITS-1:0]  rem_q;
	logic [MOD_BITS-1:0]  mod_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [MOD_BITS-1:0]  result_q;

	logic [MOD_BITS:0]    r1_full;
	logic [MOD_BITS-1:0]  r1;
	logic [MOD_BITS:0]    r2_full;
	logic [MOD_BITS-1:0]  r2;

	// Two restoring steps: shift in the next product bit, subtract when not below the modulus.
	always_comb begin
		r1_full = {rem_q, prod_q[PROD_BITS-1]};
		if (r1_full >= {1'b0, mod_q}) begin
			r1_full = r1_full - {1'b0, mod_q};
		end
		r1 = r1_full[MOD_BITS-1:0];
		r2_full = {r1, prod_q[PROD_BITS-2]};
		if (r2_full >= {1'b0, mod_q}) begin
			r2_full = r2_full - {1'b0, mod_q};
		end
		r2 = r2_full[MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MM_IDLE;
			prod_q   <= '0;
			rem_q    <= '0;
			mod_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MM_IDLE: begin
					if (start) begin
						prod_q  <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
						rem_q   <= '0;
						mod_q   <= modulus;
						cnt_q   <= LAST_STEP;
						state_q <= MM_REDUCE;
					end
				end
				MM_REDUCE: begin
					rem_q  <= r2;
					prod_q <= prod_q << 2;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						// reduction by zero yields zero
						result_q <= (mod_q == '0) ? '0 : r2;
						done_q   <= 1'b1;
						state_q  <= MM_IDLE;
					end
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	assign status.busy = (state_q != MM_IDLE);
	assign status.done = done_q;
	assign result      = result_q;

endmodule

@@ design/modular_exponentiation.sv @@
// Top level: right-to-left square-and-multiply sequencer around a shared modular multiplier.
//
//   channel  ports                                   handshake
//   input    base_value, exponent, modulus           start && !busy
//   result   power_result                            done, one cycle
//
// Each modular product is one multiply and then restoring reduction, two
// reduction bits a cycle, in the shared multiplier. Every scanned
// exponent bit costs a check state, a square, and a multiply when set;
// the square after the top set bit is skipped. Reset clears all state at
// once. The result is not held off by the receiver.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MOD_BITS-1:0] base_value,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS-1:0] modulus,
	output logic                done,
	output logic [MOD_BITS-1:0] power_result
);

	localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_WAIT,
		ST_SQ_WAIT
	} state_t;

	state_t              state_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] mod_q;
	logic                done_q;
	logic [MOD_BITS-1:0] result_q;

	logic                mm_start;
	logic                mm_use_acc;
	logic [MOD_BITS-1:0] mm_a;
	logic [MOD_BITS-1:0] mm_result;
	mm_status_t          mm_status;
	logic                exp_upper_zero;

	assign exp_upper_zero = ((exp_q >> 1) == '0);

	// Launch the next product straight from the sequencer registers.
	always_comb begin
		mm_start   = 1'b0;
		mm_use_acc = 1'b0;
		case (state_q)
			ST_CHECK: begin
				if (exp_q != '0) begin
					mm_start   = 1'b1;
					mm_use_acc = exp_q[0];
				end
			end
			ST_MUL_WAIT: begin
				mm_start = mm_status.done && !exp_upper_zero;
			end
			default: begin
				mm_start   = 1'b0;
				mm_use_acc = 1'b0;
			end
		endcase
	end

	assign mm_a = mm_use_acc ? acc_q : base_q;

	mexp_modmul #(
		.MOD_BITS(MOD_BITS)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (base_q),
		.modulus (mod_q),
		.status  (mm_status),
		.result  (mm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_q    <= ONE;
			base_q   <= '0;
			exp_q    <= '0;
			mod_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						acc_q   <= ONE;
						base_q  <= base_value;
						exp_q   <= exponent;
						mod_q   <= modulus;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (exp_q == '0) begin
						result_q <= acc_q;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (exp_q[0]) begin
						state_q <= ST_MUL_WAIT;
					end else begin
						state_q <= ST_SQ_WAIT;
					end
				end
				ST_MUL_WAIT: begin
					if (mm_status.done) begin
						acc_q <= mm_result;
						if (exp_upper_zero) begin
							// no higher bits: drop the final square
							result_q <= mm_result;
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_SQ_WAIT;
						end
					end
				end
				ST_SQ_WAIT: begin
					if (mm_status.done) begin
						base_q  <= mm_result;
						exp_q   <= exp_q >> 1;
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign power_result = result_q;

endmodule

@@ bench/tb_modular_exponentiation.sv @@
// Testbench for modular_exponentiation: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_modular_exponentiation;

	localparam int MOD_BITS = 31;
	localparam int EXP_BITS = 63;
	localparam int RANDOM_ITEMS = 120;

	typedef logic [MOD_BITS-1:0] mod_word_t;
	typedef logic [EXP_BITS-1:0] exp_word_t;

	localparam mod_word_t MOD_MAX = {MOD_BITS{1'b1}};
	localparam exp_word_t EXP_MAX = {EXP_BITS{1'b1}};

	class powmod_scoreboard;
		mod_word_t powers_due[$];
		int        mismatches;
		int        results_seen;
		int        zero_exp_items;
		int        unit_mod_items;
		int        wide_exp_items;

		function new();
			mismatches = 0;
			results_seen = 0;
			zero_exp_items = 0;
			unit_mod_items = 0;
			wide_exp_items = 0;
		endfunction

		// Right-to-left square-and-multiply; a zero modulus reduces to zero.
		function mod_word_t power_mod(mod_word_t b, exp_word_t e, mod_word_t m);
			logic [63:0] acc;
			logic [63:0] sq;
			logic [63:0] mm;
			exp_word_t   rest;
			acc = 64'd1;
			sq = {33'd0, b};
			mm = {33'd0, m};
			rest = e;
			while (rest != '0) begin
				if (rest[0])
					acc = (mm == 0) ? 64'd0 : (acc * sq) % mm;
				sq = (mm == 0) ? 64'd0 : (sq * sq) % mm;
				rest = rest >> 1;
			end
			return acc[MOD_BITS-1:0];
		endfunction

		function void note_item(mod_word_t b, exp_word_t e, mod_word_t m);
			powers_due = {powers_due, power_mod(b, e, m)};
			if (e == '0)
				zero_exp_items++;
			if (m == mod_word_t'(1))
				unit_mod_items++;
			if (e[EXP_BITS-1:40] != '0)
				wide_exp_items++;
		endfunction

		function void check_result(mod_word_t actual);
			mod_word_t want;
			results_seen++;
			if (powers_due.size() == 0) begin
				$error("power_result: expected nothing, actual %0d", actual);
				mismatches++;
				return;
			end
			want = powers_due.pop_front();
			if (actual !== want) begin
				$error("power_result: expected %0d, actual %0d", want, actual);
				mismatches++;
			end
		endfunction

		function int pending();
			return powers_due.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	mod_word_t base_value = '0;
	exp_word_t exponent = '0;
	mod_word_t modulus = mod_word_t'(1);
	logic      busy;
	logic      done;
	mod_word_t power_result;

	powmod_scoreboard powers = new();
	bit quiet_stretch = 1'b0;

	modular_exponentiation #(
		.MOD_BITS(MOD_BITS),
		.EXP_BITS(EXP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.base_value(base_value),
		.exponent(exponent),
		.modulus(modulus),
		.done(done),
		.power_result(power_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check results before noting new items, so one edge orders both the same way.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				powers.check_result(power_result);
			if (start && !busy)
				powers.note_item(base_value, exponent, modulus);
		end
	end

	task automatic send_item(input mod_word_t b, input exp_word_t e, input mod_word_t m);
		start <= 1'b1;
		base_value <= b;
		exponent <= e;
		modulus <= m;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(99, 0);
		if (quiet_stretch || r < 50)
			n = 0;
		else if (r < 85)
			n = $urandom_range(3, 1);
		else if (r < 97)
			n = $urandom_range(20, 4);
		else
			n = $urandom_range(300, 50);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold the sender until every pending result is back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (powers.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		mod_word_t   b;
		mod_word_t   m;
		exp_word_t   e;
		logic [63:0] raw;
		int          r;
		int          bits;
		r = $urandom_range(99, 0);
		if (r < 20)
			b = mod_word_t'($urandom_range(15, 0));
		else if (r < 30)
			b = MOD_MAX - mod_word_t'($urandom_range(3, 0));
		else
			b = mod_word_t'($urandom);
		r = $urandom_range(99, 0);
		if (r < 10)
			m = mod_word_t'(1);
		else if (r < 20)
			m = mod_word_t'($urandom_range(16, 2));
		else if (r < 35)
			m = MOD_MAX - mod_word_t'($urandom_range(7, 0));
		else
			m = mod_word_t'($urandom);
		if (m == '0)
			m = mod_word_t'(1);
		// Keep most exponents short; the block spends cycles per exponent bit.
		r = $urandom_range(99, 0);
		if (r < 70)
			bits = $urandom_range(12, 1);
		else if (r < 90)
			bits = $urandom_range(40, 13);
		else
			bits = $urandom_range(EXP_BITS, 41);
		raw = {$urandom, $urandom};
		e = exp_word_t'(raw) & (EXP_MAX >> (EXP_BITS - bits));
		e[bits-1] = 1'b1;
		if ($urandom_range(19, 0) == 0)
			e = '0;
		send_item(b, e, m);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero exponent, unit and zero moduli, extremes, base not below modulus
		send_item('0, '0, mod_word_t'(1));
		send_item(MOD_MAX, '0, MOD_MAX);
		send_item(mod_word_t'(5), exp_word_t'(3), mod_word_t'(1));
		send_item(mod_word_t'(7), '0, mod_word_t'(1));
		send_item(MOD_MAX, EXP_MAX, MOD_MAX);
		idle_gap();
		send_item(MOD_MAX, EXP_MAX, mod_word_t'(1));
		send_item('0, exp_word_t'(1), mod_word_t'(13));
		send_item('0, EXP_MAX, MOD_MAX);
		send_item(mod_word_t'(1), EXP_MAX, MOD_MAX);
		send_item(MOD_MAX, exp_word_t'(1), mod_word_t'(2));
		send_item(mod_word_t'(100), exp_word_t'(5), mod_word_t'(7));
		idle_gap();
		send_item(mod_word_t'(2), exp_word_t'(1) << (EXP_BITS - 1), MOD_MAX);
		send_item(MOD_MAX - mod_word_t'(1), exp_word_t'(2), MOD_MAX);
		send_item(mod_word_t'(3), exp_word_t'(5), '0);
		send_item(mod_word_t'(3), '0, '0);
		send_item(MOD_MAX, EXP_MAX, '0);
		send_item(mod_word_t'(12345), exp_word_t'({32{2'b01}}), mod_word_t'(1000003));
		send_item(MOD_MAX, exp_word_t'({32{2'b10}}), mod_word_t'(1) << (MOD_BITS - 1));
		send_item(mod_word_t'(2), exp_word_t'(31), MOD_MAX);
		send_item(mod_word_t'({16{2'b10}}), exp_word_t'(7), mod_word_t'({16{2'b01}}));
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// every third stretch of 20 items skips the random idle gaps
			quiet_stretch = ((i / 20) % 3 == 1);
			send_random_item();
			if (i % 35 == 34)
				drain();
			else
				idle_gap();
		end

		start <= 1'b0;
		while (powers.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Checked %0d results: %0d with zero exponent, %0d with unit modulus,",
			powers.results_seen, powers.zero_exp_items, powers.unit_mod_items);
		$display("%0d with exponents past 40 bits, plus zero-modulus and extreme operands.",
			powers.wide_exp_items);
		if (powers.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#30ms;
		$display("Timed out with %0d results pending", powers.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
